// ===== rtl/core/fbpa_pkg.sv =====
// ============================================================================
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ============================================================================
package fbpa_pkg;

    localparam int unsigned SLOTS         = 8;
    localparam int unsigned IDX_W         = 3;
    localparam int unsigned SIZE_W        = 16;
    localparam int unsigned TASK_W        = 8;
    localparam int unsigned MS_W          = 16;
    localparam int unsigned HOLD_W        = 32;
    localparam int unsigned CNT_W         = 4;
    localparam int unsigned MS_PER_SECOND = 1000;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_WAIT      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_SELF_HELD = 3'd3,
        ST_IDLE_FREE = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== rtl/core/fbpa_ctrl.sv =====
// ============================================================================
// fbpa_ctrl
// Controller: input and output handshakes and the two-state sequence.
// ============================================================================
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   exec_fire;

    // The item is executed once the output register is empty or being emptied.
    assign exec_fire  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state == S_EXEC);
    assign o_out_valid = r_out_valid;
    assign o_cmd.capture = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.exec    = exec_fire;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/fbpa_dp.sv =====
// ============================================================================
// fbpa_dp
// Datapath: block sizes, pool state, first-fit search and result registers.
// ============================================================================
module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS   = 8,
    parameter int unsigned WARN_SECONDS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic [1:0]        i_op,
    input  logic [SIZE_W-1:0] i_request_size,
    input  logic [IDX_W-1:0]  i_free_index,
    input  logic [TASK_W-1:0] i_task_id,
    input  logic [MS_W-1:0]   i_elapsed_ms,
    output logic [2:0]        o_status,
    output logic [IDX_W-1:0]  o_granted_index,
    output logic              o_overlong_hold,
    output logic              o_foreign_free,
    output logic              o_count_underflow,
    output logic [CNT_W-1:0]  o_in_use_count,
    output logic [CNT_W-1:0]  o_peak_count,
    output logic [HOLD_W-1:0] o_peak_hold_ms
);

    localparam logic [IDX_W:0]    NUM_B   = (IDX_W+1)'(NUM_BLOCKS);
    localparam logic [HOLD_W-1:0] WARN_MS = HOLD_W'(WARN_SECONDS * MS_PER_SECOND);
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    // Configuration and pool state.
    logic [SIZE_W-1:0] r_size [SLOTS];
    logic [SLOTS-1:0]  r_in_use, n_in_use;
    logic [TASK_W-1:0] r_owner [SLOTS];
    logic [TASK_W-1:0] n_owner [SLOTS];
    logic [HOLD_W-1:0] r_hold [SLOTS];
    logic [HOLD_W-1:0] n_hold [SLOTS];
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_peak, n_peak;
    logic [HOLD_W-1:0] r_peak_hold, n_peak_hold;

    // Captured transaction.
    t_op               r_op;
    logic [SIZE_W-1:0] r_req;
    logic [IDX_W-1:0]  r_fidx;
    logic [TASK_W-1:0] r_task;
    logic [MS_W-1:0]   r_ms;

    // Result registers.
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_granted, n_granted;
    logic              r_over, n_over;
    logic              r_foreign, n_foreign;
    logic              r_under, n_under;

    logic [SLOTS-1:0]  fit;
    logic [SLOTS-1:0]  free_fit;
    logic              other_held;
    logic              found;
    logic [IDX_W-1:0]  gidx;
    logic [IDX_W-1:0]  sel_idx;
    logic [HOLD_W-1:0] sel_hold;
    logic              sel_over;
    logic              fidx_ok;
    logic [HOLD_W:0]   sum [SLOTS];

    // First-fit search: compare against every block in parallel.
    always_comb begin
        fit        = '0;
        other_held = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i < NUM_BLOCKS) begin
                fit[i] = (r_size[i] >= r_req);
            end
            if (fit[i] && r_in_use[i] && (r_owner[i] != r_task)) begin
                other_held = 1'b1;
            end
        end
        free_fit = fit & ~r_in_use;
        found    = |free_fit;
        gidx     = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_fit[i]) begin
                gidx = IDX_W'(i);
            end
        end
    end

    // One hold-time read port, shared by grant and free.
    assign sel_idx  = (r_op == OP_ALLOC) ? gidx : r_fidx;
    assign sel_hold = r_hold[sel_idx];
    assign sel_over = (sel_hold >= WARN_MS);
    assign fidx_ok  = ({1'b0, r_fidx} < NUM_B);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            sum[i] = {1'b0, r_hold[i]} + (HOLD_W+1)'(r_ms);
        end
    end

    always_comb begin
        n_in_use    = r_in_use;
        n_owner     = r_owner;
        n_hold      = r_hold;
        n_used      = r_used;
        n_peak      = r_peak;
        n_peak_hold = r_peak_hold;
        n_status    = ST_OK;
        n_granted   = '0;
        n_over      = 1'b0;
        n_foreign   = 1'b0;
        n_under     = 1'b0;
        case (r_op)
            OP_ALLOC: begin
                if (found) begin
                    n_over = sel_over;
                    if (r_used != CNT_MAX) begin
                        n_used = r_used + 1'b1;
                    end
                    if (n_used > r_peak) begin
                        n_peak = n_used;
                    end
                    if (sel_hold > r_peak_hold) begin
                        n_peak_hold = sel_hold;
                    end
                    n_in_use[gidx] = 1'b1;
                    n_owner[gidx]  = r_task;
                    n_hold[gidx]   = '0;
                    n_granted      = gidx;
                end else if (!(|fit)) begin
                    n_status = ST_TOO_LARGE;
                end else if (other_held) begin
                    n_status = ST_WAIT;
                end else begin
                    n_status = ST_SELF_HELD;
                end
            end
            OP_FREE: begin
                if (!fidx_ok) begin
                    n_status = ST_IDLE_FREE;
                end else begin
                    n_over = sel_over;
                    if (!r_in_use[r_fidx]) begin
                        n_status = ST_IDLE_FREE;
                    end
                    n_in_use[r_fidx] = 1'b0;
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end else begin
                        n_under = 1'b1;
                    end
                    n_foreign = (r_owner[r_fidx] != r_task);
                end
            end
            OP_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_in_use[i]) begin
                        n_hold[i] = sum[i][HOLD_W] ? '1 : sum[i][HOLD_W-1:0];
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_size[i]  <= '0;
                r_owner[i] <= '0;
                r_hold[i]  <= '0;
            end
            r_in_use    <= '0;
            r_used      <= '0;
            r_peak      <= '0;
            r_peak_hold <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size[i_cfg_index] <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_in_use    <= n_in_use;
                r_owner     <= n_owner;
                r_hold      <= n_hold;
                r_used      <= n_used;
                r_peak      <= n_peak;
                r_peak_hold <= n_peak_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_op);
            r_req  <= i_request_size;
            r_fidx <= i_free_index;
            r_task <= i_task_id;
            r_ms   <= i_elapsed_ms;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_over    <= n_over;
            r_foreign <= n_foreign;
            r_under   <= n_under;
        end
    end

    assign o_status          = r_status;
    assign o_granted_index   = r_granted;
    assign o_overlong_hold   = r_over;
    assign o_foreign_free    = r_foreign;
    assign o_count_underflow = r_under;
    assign o_in_use_count    = r_used;
    assign o_peak_count      = r_peak;
    assign o_peak_hold_ms    = r_peak_hold;

endmodule

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// ============================================================================
// fixed_block_pool_allocator
// First-fit allocator over a pool of fixed-size blocks with hold-time stats.
// ============================================================================
// Usage:
// An operation (allocate, free or tick) enters on the input channel when
// i_in_valid is high and o_in_stall is low. Exactly one result leaves on the
// output channel for each operation, taken when o_out_valid is high and
// i_out_stall is low.
// Each operation passes through a capture step, which registers the
// transaction, and an execute step, which searches the pool and updates its
// state, with all blocks compared in parallel. The result is valid in the
// cycle after the update; o_in_stall is high until the operation executes.
// The result sits in an output register, so a new operation is accepted
// while the previous result is still waiting; execution of that operation
// is held while the receiver stalls and the output register is full.
// Block sizes are written on the configuration channel (index 0 to 7) by the
// user only while the block is idle (not enforced); o_cfg_ready is always high.
// Synchronous reset clears the block sizes, all pool state and statistics.
// ============================================================================
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS   = 8,
    parameter int unsigned WARN_SECONDS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [SIZE_W-1:0] i_request_size,
    input  logic [IDX_W-1:0]  i_free_index,
    input  logic [TASK_W-1:0] i_task_id,
    input  logic [MS_W-1:0]   i_elapsed_ms,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [IDX_W-1:0]  o_granted_index,
    output logic              o_overlong_hold,
    output logic              o_foreign_free,
    output logic              o_count_underflow,
    output logic [CNT_W-1:0]  o_in_use_count,
    output logic [CNT_W-1:0]  o_peak_count,
    output logic [HOLD_W-1:0] o_peak_hold_ms,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    fbpa_dp #(
        .NUM_BLOCKS   (NUM_BLOCKS),
        .WARN_SECONDS (WARN_SECONDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_request_size    (i_request_size),
        .i_free_index      (i_free_index),
        .i_task_id         (i_task_id),
        .i_elapsed_ms      (i_elapsed_ms),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_overlong_hold   (o_overlong_hold),
        .o_foreign_free    (o_foreign_free),
        .o_count_underflow (o_count_underflow),
        .o_in_use_count    (o_in_use_count),
        .o_peak_count      (o_peak_count),
        .o_peak_hold_ms    (o_peak_hold_ms)
    );

endmodule

// ===== rtl/core/fbpa_checker.sv =====
// ============================================================================
// fbpa_checker
// Port-level checks of the allocator, bound to the top level.
// ============================================================================
module fbpa_checker
    import fbpa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [2:0]        o_status,
    input logic [IDX_W-1:0]  o_granted_index,
    input logic [CNT_W-1:0]  o_in_use_count,
    input logic [CNT_W-1:0]  o_peak_count,
    input logic [HOLD_W-1:0] o_peak_hold_ms
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_peak_hold_ms))
        else $error("stalled result changed");

    // Only one operation is in flight: an accepted transaction stalls the input.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted during execution");

    // The peak count never falls below the current count.
    a_peak_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_peak_count >= o_in_use_count)
        else $error("peak count below in-use count");

    // A result with a status other than OK reports no granted index.
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_granted_index == '0)
        else $error("granted index set without a grant");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_granted_index (o_granted_index),
    .o_in_use_count  (o_in_use_count),
    .o_peak_count    (o_peak_count),
    .o_peak_hold_ms  (o_peak_hold_ms)
);

// ===== tb/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the fixed block pool allocator. A queue of
// allocate, free, tick and unused operations feeds a bursty driver, a
// cycle-free model of the pool predicts each result, and a monitor behind a
// stalling receiver compares every result field by field. The run covers
// several block size settings, a directed opening and a tick soak that
// builds a long hold time on one block.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int unsigned NUM_BLOCKS   = 8;
    localparam int unsigned WARN_SECONDS = 10;
    localparam int unsigned WARN_MS      = WARN_SECONDS * MS_PER_SECOND;
    localparam int unsigned MAX_PRINTED  = 50;

    typedef struct {
        t_op                op;
        logic [SIZE_W-1:0]  req;
        logic [IDX_W-1:0]   fidx;
        logic [TASK_W-1:0]  task_id;
        logic [MS_W-1:0]    ms;
        bit                 drain;
    } t_pool_op;

    typedef struct {
        t_status            status;
        logic [IDX_W-1:0]   grant;
        logic               over;
        logic               foreign;
        logic               under;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   peak;
        logic [HOLD_W-1:0]  peak_hold;
    } t_pool_outcome;

    typedef struct {
        logic [IDX_W-1:0]   index;
        logic [SIZE_W-1:0]  data;
    } t_size_write;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic [1:0]         in_op          = '0;
    logic [SIZE_W-1:0]  in_req         = '0;
    logic [IDX_W-1:0]   in_fidx        = '0;
    logic [TASK_W-1:0]  in_task        = '0;
    logic [MS_W-1:0]    in_ms          = '0;
    logic               out_stall      = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic [IDX_W-1:0]   cfg_index      = '0;
    logic [SIZE_W-1:0]  cfg_data       = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_status;
    logic [IDX_W-1:0]   o_granted_index;
    logic               o_overlong_hold;
    logic               o_foreign_free;
    logic               o_count_underflow;
    logic [CNT_W-1:0]   o_in_use_count;
    logic [CNT_W-1:0]   o_peak_count;
    logic [HOLD_W-1:0]  o_peak_hold_ms;
    logic               o_cfg_ready;

    // Model of the pool.
    logic [SIZE_W-1:0]  capacity_q [SLOTS];
    logic               busy_q     [SLOTS];
    logic [TASK_W-1:0]  owner_q    [SLOTS];
    logic [HOLD_W-1:0]  held_ms_q  [SLOTS];
    logic [CNT_W-1:0]   count_q     = '0;
    logic [CNT_W-1:0]   peak_q      = '0;
    logic [HOLD_W-1:0]  peak_hold_q = '0;

    // Sizes of the current setting, used to aim allocate requests.
    logic [SIZE_W-1:0]  cap_plan [SLOTS];

    t_pool_op           pool_requests [$];
    t_pool_outcome      pool_outcomes [$];
    t_size_write        size_writes   [$];
    t_pool_op           cur_op;
    int                 outcomes_due   = 0;
    int                 writes_left    = 0;
    int                 mismatches     = 0;
    int                 result_no      = 0;
    int                 burst_left     = 0;
    int                 gap_left       = 0;
    int                 stall_span     = 0;
    int                 stall_mode     = 0;

    fixed_block_pool_allocator #(
        .NUM_BLOCKS   (NUM_BLOCKS),
        .WARN_SECONDS (WARN_SECONDS)
    ) uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (in_op),
        .i_request_size    (in_req),
        .i_free_index      (in_fidx),
        .i_task_id         (in_task),
        .i_elapsed_ms      (in_ms),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_overlong_hold   (o_overlong_hold),
        .o_foreign_free    (o_foreign_free),
        .o_count_underflow (o_count_underflow),
        .o_in_use_count    (o_in_use_count),
        .o_peak_count      (o_peak_count),
        .o_peak_hold_ms    (o_peak_hold_ms),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            capacity_q[i] = '0;
            busy_q[i]     = 1'b0;
            owner_q[i]    = '0;
            held_ms_q[i]  = '0;
            cap_plan[i]   = '0;
        end
    end

    // Applies one operation to the pool model and returns its result.
    function automatic t_pool_outcome pool_apply(t_pool_op t);
        t_pool_outcome r;
        bit            fits;
        bit            other;
        bit            done;
        logic [HOLD_W:0] sum;
        fits      = 1'b0;
        other     = 1'b0;
        done      = 1'b0;
        r.status  = ST_OK;
        r.grant   = '0;
        r.over    = 1'b0;
        r.foreign = 1'b0;
        r.under   = 1'b0;
        case (t.op)
            OP_ALLOC: begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (!done && capacity_q[i] >= t.req) begin
                        fits = 1'b1;
                        if (!busy_q[i]) begin
                            r.over = (held_ms_q[i] >= WARN_MS);
                            if (count_q < 4'd15)
                                count_q = count_q + 1'b1;
                            if (count_q > peak_q)
                                peak_q = count_q;
                            if (held_ms_q[i] > peak_hold_q)
                                peak_hold_q = held_ms_q[i];
                            busy_q[i]    = 1'b1;
                            owner_q[i]   = t.task_id;
                            held_ms_q[i] = '0;
                            r.grant      = IDX_W'(i);
                            done         = 1'b1;
                        end else if (owner_q[i] != t.task_id) begin
                            other = 1'b1;
                        end
                    end
                end
                if (!done)
                    r.status = !fits ? ST_TOO_LARGE : (other ? ST_WAIT : ST_SELF_HELD);
            end
            OP_FREE: begin
                if (int'(t.fidx) >= NUM_BLOCKS) begin
                    r.status = ST_IDLE_FREE;
                end else begin
                    r.over = (held_ms_q[t.fidx] >= WARN_MS);
                    if (!busy_q[t.fidx])
                        r.status = ST_IDLE_FREE;
                    busy_q[t.fidx] = 1'b0;
                    if (count_q > 0)
                        count_q = count_q - 1'b1;
                    else
                        r.under = 1'b1;
                    r.foreign = (owner_q[t.fidx] != t.task_id);
                end
            end
            OP_TICK: begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (busy_q[i]) begin
                        sum = {1'b0, held_ms_q[i]} + t.ms;
                        held_ms_q[i] = sum[HOLD_W] ? '1 : sum[HOLD_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        r.count     = count_q;
        r.peak      = peak_q;
        r.peak_hold = peak_hold_q;
        return r;
    endfunction

    function automatic t_pool_op make_op(t_op op, logic [SIZE_W-1:0] req,
                                         logic [IDX_W-1:0] fidx,
                                         logic [TASK_W-1:0] id,
                                         logic [MS_W-1:0] ms);
        t_pool_op t;
        t.op      = op;
        t.req     = req;
        t.fidx    = fidx;
        t.task_id = id;
        t.ms      = ms;
        t.drain   = 1'b0;
        return t;
    endfunction

    // Mostly a few task ids so that self-held and foreign cases come up often;
    // allocate sizes mostly sit on a block size or one off it.
    function automatic t_pool_op random_op();
        t_pool_op    t;
        int unsigned sel;
        sel       = $urandom_range(0, 99);
        t.req     = SIZE_W'($urandom);
        t.fidx    = IDX_W'($urandom);
        t.ms      = MS_W'($urandom);
        t.task_id = ($urandom_range(0, 4) == 0) ? TASK_W'($urandom)
                                                : TASK_W'($urandom_range(0, 3));
        t.drain   = ($urandom_range(0, 199) == 0);
        if (sel < 45) begin
            t.op = OP_ALLOC;
            if (sel >= 10)
                t.req = cap_plan[$urandom_range(0, SLOTS - 1)]
                        + SIZE_W'($urandom_range(0, 2)) - 1'b1;
        end else if (sel < 80) begin
            t.op = OP_FREE;
        end else if (sel < 95) begin
            t.op = OP_TICK;
            if (sel < 88)
                t.ms = MS_W'($urandom_range(0, 4000));
        end else begin
            t.op = OP_NONE;
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch in result %0d, %s: got %0h, expected %0h",
                     result_no, what, got, want);
    endtask

    task automatic program_sizes(input int setting);
        logic [SIZE_W-1:0] picks [5];
        t_size_write       w;
        picks = '{16'd0, 16'd1, 16'd64, 16'd100, 16'hFFFF};
        for (int i = 0; i < SLOTS; i++) begin
            case (setting)
                0: cap_plan[i] = '0;
                1: cap_plan[i] = '1;
                2: cap_plan[i] = SIZE_W'(i * 8);
                3: cap_plan[i] = SIZE_W'($urandom);
                4: cap_plan[i] = picks[$urandom_range(0, 4)];
                5: cap_plan[i] = SIZE_W'(65535 - i * 1000);
                default: begin
                    picks[0]    = 16'd0;
                    cap_plan[i] = (i == 0) ? 16'd0 : SIZE_W'(16 << ((i - 1) * 2));
                    if (i == SLOTS - 1)
                        cap_plan[i] = '1;
                end
            endcase
            w.index = IDX_W'(i);
            w.data  = cap_plan[i];
            size_writes.push_back(w);
            writes_left++;
        end
        while (writes_left != 0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pool_requests.size() != 0 || outcomes_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk) begin : size_writer
        t_size_write w;
        if (cfg_valid && o_cfg_ready) begin
            capacity_q[cfg_index] = cfg_data;
            writes_left--;
        end
        if (!cfg_valid || o_cfg_ready) begin
            if (size_writes.size() != 0) begin
                w = size_writes.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.index;
                cfg_data  <= w.data;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : op_driver
        if (in_valid && !o_in_stall)
            pool_outcomes.push_back(pool_apply(cur_op));
        if (!in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pool_requests.size() != 0 &&
                         !(pool_requests[0].drain && outcomes_due != 0)) begin
                cur_op = pool_requests.pop_front();
                outcomes_due++;
                in_valid <= 1'b1;
                in_op    <= cur_op.op;
                in_req   <= cur_op.req;
                in_fidx  <= cur_op.fidx;
                in_task  <= cur_op.task_id;
                in_ms    <= cur_op.ms;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        t_pool_outcome want;
        if (rst_n && o_out_valid && !out_stall) begin
            result_no++;
            if (pool_outcomes.size() == 0) begin
                report_mismatch("result with no operation pending", o_status, '0);
            end else begin
                want = pool_outcomes.pop_front();
                outcomes_due--;
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_granted_index !== want.grant)
                    report_mismatch("granted_index", o_granted_index, want.grant);
                if (o_overlong_hold !== want.over)
                    report_mismatch("overlong_hold", o_overlong_hold, want.over);
                if (o_foreign_free !== want.foreign)
                    report_mismatch("foreign_free", o_foreign_free, want.foreign);
                if (o_count_underflow !== want.under)
                    report_mismatch("count_underflow", o_count_underflow, want.under);
                if (o_in_use_count !== want.count)
                    report_mismatch("in_use_count", o_in_use_count, want.count);
                if (o_peak_count !== want.peak)
                    report_mismatch("peak_count", o_peak_count, want.peak);
                if (o_peak_hold_ms !== want.peak_hold)
                    report_mismatch("peak_hold_ms", o_peak_hold_ms, want.peak_hold);
            end
        end
    end

    // The receiver alternates between free-running, scattered stalls and
    // long stall runs.
    always @(posedge clk) begin : stall_pattern
        if (stall_span == 0) begin
            stall_span = $urandom_range(8, 64);
            stall_mode = $urandom_range(0, 2);
        end
        stall_span--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= (stall_span % 12) < 7;
        endcase
    end

    initial begin : stimulus
        t_pool_op t;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening over sizes 0, 16, 64, 256, 1024, 4096, 16384, 65535.
        program_sizes(6);
        pool_requests.push_back(make_op(OP_ALLOC, 16'd0, 3'd0, 8'd1, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'hFFFF, 3'd7, 8'd2, 16'hFFFF));
        pool_requests.push_back(make_op(OP_ALLOC, 16'hFFFF, 3'd0, 8'd2, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'hFFFF, 3'd0, 8'd3, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'd17, 3'd0, 8'hFF, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'd16, 3'd0, 8'd0, 16'd0));
        pool_requests.push_back(make_op(OP_TICK, 16'd0, 3'd0, 8'd0, 16'd0));
        pool_requests.push_back(make_op(OP_TICK, 16'hFFFF, 3'd7, 8'hFF, 16'hFFFF));
        // A foreign free of a block held past the warning limit.
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd7, 8'd3, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'd40000, 3'd0, 8'd4, 16'd0));
        t = make_op(OP_FREE, 16'd0, 3'd7, 8'd4, 16'd0);
        t.drain = 1'b1;
        pool_requests.push_back(t);
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd7, 8'd4, 16'd0));
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd0, 8'd1, 16'd0));
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd1, 8'd0, 16'd0));
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd3, 8'hFF, 16'd0));
        // Idle free with the count already at zero.
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd5, 8'd0, 16'd0));
        pool_requests.push_back(make_op(OP_NONE, 16'hFFFF, 3'd7, 8'hFF, 16'hFFFF));
        pool_requests.push_back(make_op(OP_ALLOC, 16'd0, 3'd0, 8'd0, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'd65535, 3'd0, 8'd9, 16'd0));
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd0, 8'd0, 16'd0));
        wait_drained();

        for (int setting = 0; setting < 6; setting++) begin
            program_sizes(setting);
            repeat (135) pool_requests.push_back(random_op());
            wait_drained();
        end

        // Soak: one block held through a run of maximal ticks, then released
        // and granted again to expose the long hold time as the peak.
        for (int i = 0; i < SLOTS; i++)
            pool_requests.push_back(make_op(OP_FREE, 16'd0, IDX_W'(i), 8'd0, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'd0, 3'd0, 8'd6, 16'd0));
        repeat (40) pool_requests.push_back(make_op(OP_TICK, 16'd0, 3'd0, 8'd6, 16'hFFFF));
        pool_requests.push_back(make_op(OP_FREE, 16'd0, 3'd0, 8'd6, 16'd0));
        pool_requests.push_back(make_op(OP_ALLOC, 16'd0, 3'd0, 8'd6, 16'd0));
        repeat (20) pool_requests.push_back(random_op());
        wait_drained();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("fixed_block_pool_allocator verification clean");
        else
            $display("fixed_block_pool_allocator verification failed");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("fixed_block_pool_allocator verification failed");
        $finish;
    end

endmodule
